@@ src/psn_pkg.sv @@
// Shared types, character codes and helpers for the path separator normaliser.
package psn_pkg;

	localparam int DEF_BUF_DEPTH = 1024;
	localparam int QUEUE_DEPTH   = 2;

	localparam int CHAR_W    = 8;
	localparam int IDX_W     = 10;
	localparam int LEN_W     = 11;
	localparam int CAP_W     = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CHAR_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	// look-back window used when testing a '..' segment
	localparam logic [2:0] WIN_LEN = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TO_BACKSLASH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_KEEP_PARENT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY     = 2'd2;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [2:0] {
		OP_READ,
		OP_NUL,
		OP_SEP,
		OP_DOT,
		OP_CHAR
	} op_t;

	typedef struct packed {
		logic              to_backslash;
		logic              keep_leading_parent;
		logic [CAP_W-1:0]  capacity;
	} cfg_t;

	typedef struct packed {
		op_t               op;
		logic              start;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
	} item_t;

	typedef struct packed {
		logic [LEN_W-1:0]  length;
		logic              overflow;
		logic [CHAR_W-1:0] read_char;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_SEP_CHK,
		ST_WIN,
		ST_DOT_EVAL,
		ST_B1_RD,
		ST_B1_CHK,
		ST_B2_RD,
		ST_B2_CHK,
		ST_CL,
		ST_CL_CHK1,
		ST_CL_CHK2,
		ST_FIN
	} back_st_t;

	function automatic logic [CHAR_W-1:0] sep_char(input logic to_bs);
		return to_bs ? CHAR_BSLASH : CHAR_SLASH;
	endfunction

	function automatic logic is_sep(input logic [CHAR_W-1:0] c);
		return (c == CHAR_SLASH) || (c == CHAR_BSLASH);
	endfunction

endpackage

@@ src/path_separator_normalizer_unit.sv @@
// Top level of the path separator normaliser: config registers, queues, front and back.
// Usage
//   Input side is a queue: present kind/char_value/last/read_index and raise push;
//   the transfer happens on a clock edge with push high and full low. Kind 0 feeds one
//   path byte (last closes the path), kind 1 reads a stored byte of the current path.
//   Result side is a queue too: while empty is low the oldest result sits on
//   length/overflow/read_char, and an edge with pop high takes it. One result per item.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high. Write it only while no item is in flight.
// Sequencing
//   Items pass a two-entry queue to the back-end sequencer, which owns the single write
//   port and single read port of the line store. A NUL byte, an item after overflow or
//   a read past the length is answered from the idle state; a read hit passes a read
//   wait state; a plain byte passes the finish state; a separator passes the separator
//   check and finish; a dot fills the look-back window and is evaluated, and a resolved
//   '..' then scans the store back and runs the collapse check before finish.
// Reset and stalls
//   Reset restores the register defaults, empties both queues and marks the next byte as
//   a path start; the store is not cleared. If the receiver holds off, the two-entry
//   result queue fills, the sequencer holds, the input queue fills and full rises.
module path_separator_normalizer_unit
	import psn_pkg::*;
#(
	parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 kind,
	input  logic [CHAR_W-1:0]    char_value,
	input  logic                 last,
	input  logic [IDX_W-1:0]     read_index,
	output logic                 empty,
	input  logic                 pop,
	output logic [LEN_W-1:0]     length,
	output logic                 overflow,
	output logic [CHAR_W-1:0]    read_char,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_data
);

	cfg_t  cfg_q;

	// front to back queue
	logic  mid_push;
	item_t mid_wdata;
	logic  mid_full;
	logic  mid_pop;
	item_t mid_rdata;
	logic  mid_empty;

	// back to result queue
	logic  res_push;
	res_t  res_wdata;
	logic  res_full;
	res_t  res_rdata;

	assign cfg_ready = 1'b1;

	// config writes: an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.to_backslash        <= 1'b0;
			cfg_q.keep_leading_parent <= 1'b0;
			cfg_q.capacity            <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_IDX_TO_BACKSLASH: cfg_q.to_backslash        <= cfg_data[0];
				CFG_IDX_KEEP_PARENT:  cfg_q.keep_leading_parent <= cfg_data[0];
				CFG_IDX_CAPACITY:     cfg_q.capacity            <= cfg_data;
				default:              cfg_q                     <= cfg_q;
			endcase
		end
	end

	psn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.char_value (char_value),
		.last       (last),
		.read_index (read_index),
		.q_push     (mid_push),
		.q_item     (mid_wdata),
		.q_full     (mid_full)
	);

	psn_fifo #(
		.W     ($bits(item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	psn_back #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (mid_empty),
		.q_item  (mid_rdata),
		.q_pop   (mid_pop),
		.o_full  (res_full),
		.o_push  (res_push),
		.o_res   (res_wdata)
	);

	psn_fifo #(
		.W     ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign length    = res_rdata.length;
	assign overflow  = res_rdata.overflow;
	assign read_char = res_rdata.read_char;

	// the sequencer only starts an item when the result queue has room
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("sequencer took from an empty queue");

	a_item_queued: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> !mid_empty)
		else $error("accepted item missing from the queue");

	a_ovf_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && overflow |-> length == '0)
		else $error("overflowed result with non-zero length");

endmodule

@@ src/psn_fifo.sv @@
// Small register queue with push/full and pop/empty sides.
module psn_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

@@ src/psn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module psn_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/psn_front.sv @@
// Front end: accepts items, classifies characters and tracks path starts.
module psn_front
	import psn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              kind,
	input  logic [CHAR_W-1:0] char_value,
	input  logic              last,
	input  logic [IDX_W-1:0]  read_index,
	output logic              q_push,
	output item_t             q_item,
	input  logic              q_full
);

	logic path_done_q;
	op_t  char_op;

	assign full   = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		unique case (char_value) inside
			CHAR_NUL: begin
				char_op = OP_NUL;
			end
			CHAR_SLASH, CHAR_BSLASH: begin
				char_op = OP_SEP;
			end
			CHAR_DOT: begin
				char_op = OP_DOT;
			end
			default: begin
				char_op = OP_CHAR;
			end
		endcase
	end

	always_comb begin
		q_item.ch  = char_value;
		q_item.idx = read_index;
		if (kind == KIND_READ) begin
			q_item.op    = OP_READ;
			q_item.start = 1'b0;
		end else begin
			q_item.op    = char_op;
			q_item.start = path_done_q;
		end
	end

	// a character transfer with last set closes the path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_done_q <= 1'b1;
		end else if (q_push && kind == KIND_CHAR) begin
			path_done_q <= last;
		end
	end

endmodule

@@ src/psn_back.sv @@
// Back end: sequencer that edits the line store and produces results.
module psn_back
	import psn_pkg::*;
#(
	parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_empty,
	input  item_t q_item,
	output logic  q_pop,
	input  logic  o_full,
	output logic  o_push,
	output res_t  o_res
);

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int PW = AW + 2;
	localparam logic signed [PW-1:0] P_ONE = PW'(1);
	localparam logic signed [PW-1:0] P_TWO = PW'(2);

	back_st_t state_q, state_d;

	logic signed [PW-1:0] pos_q;
	logic                 ovf_q;
	logic signed [PW-1:0] cur_q;
	logic [CHAR_W-1:0]    win_q [5];
	logic [2:0]           k_q;
	logic                 pend_q;
	logic                 prev_ok_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CHAR_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CHAR_W-1:0] ram_rdata;

	logic [CHAR_W-1:0]    sep;
	logic signed [PW-1:0] cap_s;
	logic                 cap_zero;
	logic                 take;
	logic signed [PW-1:0] eff_pos;
	logic                 eff_ovf;
	logic                 quick;
	logic [LEN_W-1:0]     eff_len;
	logic                 rd_hit;
	logic signed [PW-1:0] eff_pm1;
	logic signed [PW-1:0] cur_pm1;
	logic signed [PW-1:0] cur_pm2;
	logic signed [PW-1:0] cur_pp1;
	logic signed [PW-1:0] win_pos;
	logic                 win_issue;
	logic                 cur_gt0;
	logic                 cur_ge2;
	logic                 dot_cond;
	logic                 fin_ovf;
	logic                 rd_sep;

	function automatic logic [LEN_W-1:0] len_of(input logic signed [PW-1:0] p, input logic ov);
		return (ov || p[PW-1]) ? '0 : LEN_W'(p);
	endfunction

	psn_ram #(
		.W     (CHAR_W),
		.DEPTH (BUF_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign sep      = sep_char(cfg.to_backslash);
	assign cap_s    = (32'(cfg.capacity) > 32'(BUF_DEPTH)) ? PW'(BUF_DEPTH) : PW'(cfg.capacity);
	assign cap_zero = (cfg.capacity == '0);
	assign take     = (state_q == ST_IDLE) && !q_empty && !o_full;
	assign eff_pos  = q_item.start ? '0 : pos_q;
	assign eff_ovf  = q_item.start ? 1'b0 : ovf_q;
	assign quick    = cap_zero || eff_ovf || (q_item.op == OP_NUL);
	assign eff_len  = len_of(eff_pos, eff_ovf);
	assign rd_hit   = {1'b0, q_item.idx} < eff_len;
	assign eff_pm1  = eff_pos - P_ONE;
	assign cur_pm1  = cur_q - P_ONE;
	assign cur_pm2  = cur_q - P_TWO;
	assign cur_pp1  = cur_q + P_ONE;
	assign win_pos  = cur_q - signed'(PW'(k_q));
	assign win_issue = (k_q <= WIN_LEN) && !win_pos[PW-1];
	assign cur_gt0  = (cur_q > 0);
	assign cur_ge2  = (cur_q >= 2);
	assign fin_ovf  = (cur_q >= cap_s);
	assign rd_sep   = (ram_rdata == sep);

	// a '..' segment is not resolved when glued to a kept parent segment
	always_comb begin
		logic c1_dot, c2_sep, c3_dot, c4_dot, c5_sep, chained, lead_ok;
		c1_dot  = (win_q[0] == CHAR_DOT);
		c2_sep  = (win_q[1] == sep);
		c3_dot  = (win_q[2] == CHAR_DOT);
		c4_dot  = (win_q[3] == CHAR_DOT);
		c5_sep  = (win_q[4] == sep);
		lead_ok = (!cfg.keep_leading_parent && cur_q == 1) || (cur_q >= 2 && c2_sep);
		chained = (cur_q >= 4) && c3_dot && c4_dot && ((cur_q == 4) || c5_sep);
		dot_cond = c1_dot && (cur_q >= 1) && lead_ok && (!cfg.keep_leading_parent || !chained);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					unique case (q_item.op)
						OP_READ: state_d = rd_hit ? ST_RD_WAIT : ST_IDLE;
						OP_SEP:  state_d = quick ? ST_IDLE : ST_SEP_CHK;
						OP_DOT:  state_d = quick ? ST_IDLE : ST_WIN;
						OP_CHAR: state_d = quick ? ST_IDLE : ST_FIN;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD_WAIT:  state_d = ST_IDLE;
			ST_SEP_CHK:  state_d = ST_FIN;
			ST_WIN:      state_d = (k_q > WIN_LEN) ? ST_DOT_EVAL : ST_WIN;
			ST_DOT_EVAL: state_d = dot_cond ? ST_B1_RD : ST_FIN;
			ST_B1_RD:    state_d = cur_gt0 ? ST_B1_CHK : ST_CL;
			ST_B1_CHK:   state_d = is_sep(ram_rdata) ? ST_B1_RD : ST_B2_RD;
			ST_B2_RD:    state_d = cur_gt0 ? ST_B2_CHK : ST_CL;
			ST_B2_CHK:   state_d = rd_sep ? ST_CL : ST_B2_RD;
			ST_CL:       state_d = cur_ge2 ? ST_CL_CHK1 : ST_FIN;
			ST_CL_CHK1:  state_d = rd_sep ? ST_CL_CHK2 : ST_FIN;
			ST_CL_CHK2:  state_d = ST_FIN;
			ST_FIN:      state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs: queue handshakes, store port and result
	always_comb begin
		q_pop     = take;
		o_push    = 1'b0;
		o_res     = '0;
		ram_we    = 1'b0;
		ram_waddr = eff_pos[AW-1:0];
		ram_wdata = q_item.ch;
		ram_re    = 1'b0;
		ram_raddr = cur_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (q_item.op == OP_READ) begin
						ram_re    = rd_hit;
						ram_raddr = AW'(q_item.idx);
						o_push    = !rd_hit;
						o_res.length   = eff_len;
						o_res.overflow = eff_ovf;
					end else if (quick) begin
						o_push = 1'b1;
						if (!cap_zero) begin
							o_res.length   = eff_len;
							o_res.overflow = eff_ovf;
						end
					end else if (q_item.op == OP_SEP) begin
						ram_we    = !eff_pos[PW-1];
						ram_wdata = sep;
						ram_re    = (eff_pos > 0);
						ram_raddr = eff_pm1[AW-1:0];
					end else if (q_item.op == OP_CHAR) begin
						ram_we = !eff_pos[PW-1];
					end
				end
			end
			ST_RD_WAIT: begin
				o_push          = 1'b1;
				o_res.length    = len_of(pos_q, ovf_q);
				o_res.overflow  = ovf_q;
				o_res.read_char = ram_rdata;
			end
			ST_WIN: begin
				ram_re    = win_issue;
				ram_raddr = win_pos[AW-1:0];
			end
			ST_DOT_EVAL: begin
				ram_we    = !dot_cond && !cur_q[PW-1];
				ram_waddr = cur_q[AW-1:0];
				ram_wdata = CHAR_DOT;
			end
			ST_B1_RD, ST_B2_RD: begin
				ram_re = cur_gt0;
			end
			ST_CL: begin
				ram_re    = cur_ge2;
				ram_raddr = cur_pm1[AW-1:0];
			end
			ST_CL_CHK1: begin
				ram_re    = rd_sep;
				ram_raddr = cur_pm2[AW-1:0];
			end
			ST_FIN: begin
				ram_we    = fin_ovf;
				ram_waddr = '0;
				ram_wdata = CHAR_NUL;
				o_push    = 1'b1;
				o_res.length   = fin_ovf ? '0 : len_of(cur_q, 1'b0);
				o_res.overflow = fin_ovf;
			end
			default: begin
				o_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				prev_ok_q <= (eff_pos > 0);
				cur_q     <= (q_item.op == OP_CHAR) ? eff_pos + P_ONE : eff_pos;
			end
			ST_SEP_CHK: begin
				if (!(prev_ok_q && rd_sep)) begin
					cur_q <= cur_pp1;
				end
			end
			ST_WIN: begin
				if (k_q >= 3'd2) begin
					for (int i = 0; i < 4; i++) begin
						win_q[i] <= win_q[i+1];
					end
					win_q[4] <= pend_q ? ram_rdata : CHAR_NUL;
				end
			end
			ST_DOT_EVAL: begin
				cur_q <= dot_cond ? cur_pm2 : cur_pp1;
			end
			ST_B1_CHK: begin
				cur_q <= cur_pm1;
			end
			ST_B2_CHK: begin
				if (!rd_sep) begin
					cur_q <= cur_pm1;
				end
			end
			ST_CL_CHK2: begin
				if (rd_sep) begin
					cur_q <= cur_pm1;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
			k_q     <= 3'd1;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take && q_item.op != OP_READ) begin
				pos_q <= cap_zero ? '0 : eff_pos;
				ovf_q <= cap_zero ? 1'b0 : eff_ovf;
				k_q    <= 3'd1;
				pend_q <= 1'b0;
			end
			if (state_q == ST_WIN) begin
				pend_q <= win_issue;
				k_q    <= k_q + 3'd1;
			end
			if (state_q == ST_FIN) begin
				pos_q <= fin_ovf ? '0 : cur_q;
				ovf_q <= fin_ovf;
			end
		end
	end

endmodule
